@@ hdl/scr_pkg.sv @@
// Shared types, widths and constants for the sRGB contrast-ratio core.
// Holds the sRGB linearization table, built at elaboration by a constant function.
// No dependencies.
package scr_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CODE_W    = 8;
  localparam int LIN_DEPTH = 256;
  localparam int LIN_W     = 17;                      // Q16, top entry is exactly 1.0
  localparam int WGT_W     = 16;
  localparam int PROD_W    = LIN_W + WGT_W;           // 33
  localparam int LUMA_W    = 33;                      // Q32 luminance, max exactly 2^32
  localparam int DEN_W     = 33;                      // luminance plus 0.05
  localparam int NUM_W     = DEN_W + FRAC_BITS + 1;   // scaled numerator plus rounding term
  localparam int RATIO_INT_W = 5;                     // integer part up to 21
  localparam int QUO_W     = FRAC_BITS + RATIO_INT_W;
  localparam int RATIO_W   = 21;

  localparam logic [WGT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WGT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WGT_W-1:0] W_BLUE  = 16'd4732;

  localparam logic [DEN_W-1:0] OFFSET_Q32 = 33'd214748365;

  localparam logic [QUO_W-1:0] Q_MIN = QUO_W'(1) << FRAC_BITS;
  localparam logic [QUO_W-1:0] Q_MAX = QUO_W'(21) << FRAC_BITS;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t fg;
    rgb_t bg;
  } color_pair_t;

  typedef struct packed {
    logic [LUMA_W-1:0] fg;
    logic [LUMA_W-1:0] bg;
  } luma_pair_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_op_t;

  typedef logic [LIN_W-1:0] lin_rom_t [LIN_DEPTH];

  // Q30 product, rounded to nearest
  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] q30_pow5(input logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int k = 0; k < 4; k++) begin
      p = q30_mul(p, y);
    end
    return p;
  endfunction

  // One table entry: linear segment near black, else ((c + 0.055) / 1.055)^2.4 in Q16.
  // The 2.4 power is v^2 times the fifth root of v^2, found by bisection.
  function automatic logic [LIN_W-1:0] lin_entry(input int unsigned i);
    logic [63:0] num;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] ii;
    ii = 64'(i);
    if (i <= 10) begin
      return LIN_W'((ii * 64'd13107200 + 64'd329460) / 64'd658920);
    end
    num = ii * 64'd1000 + 64'd14025;
    v   = (num * 64'd2147483648 + 64'd269025) / 64'd538050;
    v2  = q30_mul(v, v);
    lo  = 64'd0;
    hi  = 64'd1073741824;
    for (int s = 0; s < 32; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (q30_pow5(mid) <= v2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return LIN_W'((v2 * lo + 64'h0000_0800_0000_0000) >> 44);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int i = 0; i < LIN_DEPTH; i++) begin
      rom[i] = lin_entry(i);
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

@@ hdl/scr_luma.sv @@
// Relative luminance of both colors: table lookup, weighting, sum; three stages.
// Depends on scr_pkg.
module scr_luma (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_vld,
  input  scr_pkg::color_pair_t     up_pair,
  output logic                     up_stall,
  output logic                     dn_vld,
  output scr_pkg::luma_pair_t      dn_luma,
  input  logic                     dn_stall
);

  logic [scr_pkg::CODE_W-1:0] code_w [6];
  logic [scr_pkg::WGT_W-1:0]  wgt_w  [6];

  logic                       s0_vld_r;
  logic [scr_pkg::LIN_W-1:0]  lin_r   [6];
  logic [scr_pkg::LIN_W-1:0]  lin_nxt [6];

  logic                       s1_vld_r;
  logic [scr_pkg::PROD_W-1:0] prod_r   [6];
  logic [scr_pkg::PROD_W-1:0] prod_nxt [6];

  logic                       s2_vld_r;
  scr_pkg::luma_pair_t        luma_r;
  scr_pkg::luma_pair_t        luma_nxt;

  logic st0, st1, st2;

  assign st2      = s2_vld_r && dn_stall;
  assign st1      = s1_vld_r && st2;
  assign st0      = s0_vld_r && st1;
  assign up_stall = st0;

  // slots 0..2 foreground r/g/b, 3..5 background r/g/b
  always_comb begin
    code_w[0] = up_pair.fg.red;
    code_w[1] = up_pair.fg.green;
    code_w[2] = up_pair.fg.blue;
    code_w[3] = up_pair.bg.red;
    code_w[4] = up_pair.bg.green;
    code_w[5] = up_pair.bg.blue;
    wgt_w[0]  = scr_pkg::W_RED;
    wgt_w[1]  = scr_pkg::W_GREEN;
    wgt_w[2]  = scr_pkg::W_BLUE;
    wgt_w[3]  = scr_pkg::W_RED;
    wgt_w[4]  = scr_pkg::W_GREEN;
    wgt_w[5]  = scr_pkg::W_BLUE;
    for (int k = 0; k < 6; k++) begin
      lin_nxt[k]  = scr_pkg::LIN_ROM[code_w[k]];
      prod_nxt[k] = scr_pkg::PROD_W'(wgt_w[k]) * scr_pkg::PROD_W'(lin_r[k]);
    end
    // weights sum to 1.0, so each total fits the Q32 field
    luma_nxt.fg = scr_pkg::LUMA_W'(prod_r[0] + prod_r[1] + prod_r[2]);
    luma_nxt.bg = scr_pkg::LUMA_W'(prod_r[3] + prod_r[4] + prod_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (!st0) s0_vld_r <= up_vld;
      if (!st1) s1_vld_r <= s0_vld_r;
      if (!st2) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!st0) lin_r  <= lin_nxt;
    if (!st1) prod_r <= prod_nxt;
    if (!st2) luma_r <= luma_nxt;
  end

  assign dn_vld  = s2_vld_r;
  assign dn_luma = luma_r;

endmodule

@@ hdl/scr_order.sv @@
// Orders the two luminances, adds the 0.05 flare term and forms the rounded dividend.
// Three stages. Depends on scr_pkg.
module scr_order (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_vld,
  input  scr_pkg::luma_pair_t  up_luma,
  output logic                 up_stall,
  output logic                 dn_vld,
  output scr_pkg::div_op_t     dn_op,
  input  logic                 dn_stall
);

  logic                       s0_vld_r;
  logic [scr_pkg::LUMA_W-1:0] hi_r, lo_r, hi_nxt, lo_nxt;

  logic                       s1_vld_r;
  logic [scr_pkg::DEN_W-1:0]  hio_r, loo_r, hio_nxt, loo_nxt;

  logic                       s2_vld_r;
  scr_pkg::div_op_t           op_r, op_nxt;

  logic st0, st1, st2;

  assign st2      = s2_vld_r && dn_stall;
  assign st1      = s1_vld_r && st2;
  assign st0      = s0_vld_r && st1;
  assign up_stall = st0;

  always_comb begin
    if (up_luma.fg > up_luma.bg) begin
      hi_nxt = up_luma.fg;
      lo_nxt = up_luma.bg;
    end else begin
      hi_nxt = up_luma.bg;
      lo_nxt = up_luma.fg;
    end
    hio_nxt    = scr_pkg::DEN_W'(hi_r) + scr_pkg::OFFSET_Q32;
    loo_nxt    = scr_pkg::DEN_W'(lo_r) + scr_pkg::OFFSET_Q32;
    // half the divisor added up front gives round-to-nearest
    op_nxt.num = (scr_pkg::NUM_W'(hio_r) << scr_pkg::FRAC_BITS)
               + scr_pkg::NUM_W'(loo_r >> 1);
    op_nxt.den = loo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (!st0) s0_vld_r <= up_vld;
      if (!st1) s1_vld_r <= s0_vld_r;
      if (!st2) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!st0) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    if (!st1) begin
      hio_r <= hio_nxt;
      loo_r <= loo_nxt;
    end
    if (!st2) op_r <= op_nxt;
  end

  assign dn_vld = s2_vld_r;
  assign dn_op  = op_r;

  a_hi_not_below_lo: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (hio_r >= loo_r))
    else $error("ordered luminances swapped");

endmodule

@@ hdl/scr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// The ratio stays below 2^QUO_W, so the top dividend bits seed the remainder. Depends on scr_pkg.
module scr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_vld,
  input  scr_pkg::div_op_t           up_op,
  output logic                       up_stall,
  output logic                       dn_vld,
  output logic [scr_pkg::QUO_W-1:0]  dn_quo,
  input  logic                       dn_stall
);

  localparam int QW = scr_pkg::QUO_W;
  localparam int DW = scr_pkg::DEN_W;
  localparam int NW = scr_pkg::NUM_W;

  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];

  logic          src_vld [QW];
  logic [DW-1:0] src_rem [QW];
  logic [DW-1:0] src_den [QW];
  logic [QW-1:0] src_low [QW];
  logic [QW-1:0] src_quo [QW];

  logic [DW:0]   trial_w [QW];
  logic          ge_w    [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  logic          stall_w [QW+1];

  assign stall_w[QW] = dn_stall;

  for (genvar k = 0; k < QW; k++) begin : g_stall
    assign stall_w[k] = vld_r[k] && stall_w[k+1];
  end

  assign up_stall = stall_w[0];

  always_comb begin
    src_vld[0] = up_vld;
    src_rem[0] = DW'(up_op.num[NW-1:QW]);
    src_den[0] = up_op.den;
    src_low[0] = up_op.num[QW-1:0];
    src_quo[0] = '0;
    for (int k = 1; k < QW; k++) begin
      src_vld[k] = vld_r[k-1];
      src_rem[k] = rem_r[k-1];
      src_den[k] = den_r[k-1];
      src_low[k] = low_r[k-1];
      src_quo[k] = quo_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial_w[k] = {src_rem[k], src_low[k][QW-1]};
      ge_w[k]    = trial_w[k] >= {1'b0, src_den[k]};
      if (ge_w[k]) begin
        rem_nxt[k] = DW'(trial_w[k] - {1'b0, src_den[k]});
      end else begin
        rem_nxt[k] = trial_w[k][DW-1:0];
      end
      low_nxt[k] = src_low[k] << 1;
      quo_nxt[k] = {src_quo[k][QW-2:0], ge_w[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (!stall_w[k]) vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!stall_w[k]) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= src_den[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign dn_vld = vld_r[QW-1];
  assign dn_quo = quo_r[QW-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW-1] |-> (rem_r[QW-1] < den_r[QW-1]))
    else $error("divider remainder not reduced");

endmodule

@@ hdl/srgb_contrast_ratio_core.sv @@
// Contrast ratio of a foreground/background sRGB pair, as unsigned Q16 in 1.0 .. 21.0.
// Top level: luminance, ordering, divider and output clamp register. Depends on scr_pkg.
//
// Takes one color pair per clock and returns one ratio per pair, in order, while the
// output is not stalled. The pipeline holds three stages of table lookup, weighting and
// summing, three stages of ordering, offset and dividend forming, one stage per quotient
// bit in the divider (FRAC_BITS + 5), and the output register. Throughput is one beat
// per cycle while out_ready is high. Each stage holds only while it is full and the stage
// after it is stalled, so empty stages keep filling while a result waits on out_ready.
module srgb_contrast_ratio_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [scr_pkg::CODE_W-1:0]    in_fg_red,
  input  logic [scr_pkg::CODE_W-1:0]    in_fg_green,
  input  logic [scr_pkg::CODE_W-1:0]    in_fg_blue,
  input  logic [scr_pkg::CODE_W-1:0]    in_bg_red,
  input  logic [scr_pkg::CODE_W-1:0]    in_bg_green,
  input  logic [scr_pkg::CODE_W-1:0]    in_bg_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scr_pkg::RATIO_W-1:0]   out_ratio_q16
);

  scr_pkg::color_pair_t            pair_w;
  logic                            luma_vld, luma_stall, luma_up_stall;
  scr_pkg::luma_pair_t             luma_w;
  logic                            op_vld, op_stall;
  scr_pkg::div_op_t                op_w;
  logic                            quo_vld, out_stall;
  logic [scr_pkg::QUO_W-1:0]       quo_w;

  logic                            out_vld_r;
  logic [scr_pkg::QUO_W-1:0]       q_r, q_nxt;

  always_comb begin
    pair_w.fg.red   = in_fg_red;
    pair_w.fg.green = in_fg_green;
    pair_w.fg.blue  = in_fg_blue;
    pair_w.bg.red   = in_bg_red;
    pair_w.bg.green = in_bg_green;
    pair_w.bg.blue  = in_bg_blue;
  end

  assign in_ready = !luma_up_stall;

  scr_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (in_valid),
    .up_pair  (pair_w),
    .up_stall (luma_up_stall),
    .dn_vld   (luma_vld),
    .dn_luma  (luma_w),
    .dn_stall (luma_stall)
  );

  scr_order u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (luma_vld),
    .up_luma  (luma_w),
    .up_stall (luma_stall),
    .dn_vld   (op_vld),
    .dn_op    (op_w),
    .dn_stall (op_stall)
  );

  scr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (op_vld),
    .up_op    (op_w),
    .up_stall (op_stall),
    .dn_vld   (quo_vld),
    .dn_quo   (quo_w),
    .dn_stall (out_stall)
  );

  assign out_stall = out_vld_r && !out_ready;

  always_comb begin
    if (quo_w < scr_pkg::Q_MIN) begin
      q_nxt = scr_pkg::Q_MIN;
    end else if (quo_w > scr_pkg::Q_MAX) begin
      q_nxt = scr_pkg::Q_MAX;
    end else begin
      q_nxt = quo_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_stall) begin
      out_vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_stall) q_r <= q_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_ratio_q16 = scr_pkg::RATIO_W'(q_r);

  a_ratio_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (q_r >= scr_pkg::Q_MIN && q_r <= scr_pkg::Q_MAX))
    else $error("ratio outside clamp range");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

@@ bench/tb_srgb_contrast_ratio_core.sv @@
`timescale 1ns / 100ps
// Testbench for srgb_contrast_ratio_core: directed color pairs, then random pairs under
// several valid/ready idle patterns, each ratio checked against its typed value or a local
// luminance model. Depends on scr_pkg and srgb_contrast_ratio_core.
module tb_srgb_contrast_ratio_core;

  localparam int CODE_W = scr_pkg::CODE_W;
  localparam int RATIO_W = scr_pkg::RATIO_W;
  localparam int SCALE = 16;
  localparam longint unsigned LUM_W_RED = 13933;
  localparam longint unsigned LUM_W_GREEN = 46871;
  localparam longint unsigned LUM_W_BLUE = 4732;
  localparam longint unsigned LUM_PAD = 214748365;  // 0.05 in Q32
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << SCALE;
  localparam logic [RATIO_W-1:0] RATIO_TOP = RATIO_W'(21) << SCALE;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_PAIRS = 175;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } color_t;

  typedef struct packed {
    color_t fore;
    color_t back;
    logic typed;                  // ratio column holds the answer
    logic [RATIO_W-1:0] ratio;
  } dir_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    {24'h000000, 24'hFFFFFF, 1'b1, 21'd1376256},  // black on white saturates at 21
    {24'hFFFFFF, 24'h000000, 1'b1, 21'd1376256},  // order of the two colors is irrelevant
    {24'h000000, 24'h000000, 1'b1, 21'd65536},
    {24'hFFFFFF, 24'hFFFFFF, 1'b1, 21'd65536},
    {24'h808080, 24'h808080, 1'b1, 21'd65536},
    {24'h123456, 24'h123456, 1'b1, 21'd65536},
    {24'h0A0A0A, 24'h000000, 1'b0, 21'd0},        // top of the linear segment
    {24'h0B0B0B, 24'h000000, 1'b0, 21'd0},        // first code on the power curve
    {24'h0B0B0B, 24'h0A0A0A, 1'b0, 21'd0},
    {24'h010101, 24'h000000, 1'b0, 21'd0},
    {24'hFEFEFE, 24'hFFFFFF, 1'b0, 21'd0},
    {24'hFF0000, 24'h000000, 1'b0, 21'd0},
    {24'h00FF00, 24'h000000, 1'b0, 21'd0},
    {24'h0000FF, 24'h000000, 1'b0, 21'd0},
    {24'h000000, 24'hFF0000, 1'b0, 21'd0},
    {24'hFF00FF, 24'h00FF00, 1'b0, 21'd0},
    {24'h55AA55, 24'hAA55AA, 1'b0, 21'd0},
    {24'h777777, 24'h767676, 1'b0, 21'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CODE_W-1:0] in_fg_red = '0;
  logic [CODE_W-1:0] in_fg_green = '0;
  logic [CODE_W-1:0] in_fg_blue = '0;
  logic [CODE_W-1:0] in_bg_red = '0;
  logic [CODE_W-1:0] in_bg_green = '0;
  logic [CODE_W-1:0] in_bg_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RATIO_W-1:0] out_ratio_q16;

  logic [16:0] lin_q16 [256];
  logic [RATIO_W-1:0] pending_ratios [$];
  logic [RATIO_W-1:0] ratio_want;
  idle_mode_t idle_mode = IDLE_NONE;
  int error_count = 0;
  int pairs_sent = 0;
  int ratios_checked = 0;
  int cycle_count = 0;

  srgb_contrast_ratio_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_fg_red     (in_fg_red),
    .in_fg_green   (in_fg_green),
    .in_fg_blue    (in_fg_blue),
    .in_bg_red     (in_bg_red),
    .in_bg_green   (in_bg_green),
    .in_bg_blue    (in_bg_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ratio_q16 (out_ratio_q16)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q30 product with round to nearest
  function automatic longint unsigned q30_round_mul(input longint unsigned a,
                                                    input longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // sRGB code to linear light in Q16
  function automatic logic [16:0] srgb_to_linear_q16(input int unsigned code);
    longint unsigned c;
    longint unsigned vq;
    longint unsigned v2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    c = code;
    if (code <= 10) begin
      return 17'((c * 64'd13107200 + 64'd329460) / 64'd658920);
    end
    vq = ((c * 1000 + 14025) * 64'd2147483648 + 64'd269025) / 64'd538050;
    v2 = q30_round_mul(vq, vq);
    lo = 0;
    hi = 64'd1073741824;
    // v^2.4 = v^2 * fifth root of v^2
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      p = mid;
      repeat (4) p = q30_round_mul(p, mid);
      if (p <= v2) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return 17'((v2 * lo + 64'h0000_0800_0000_0000) >> 44);
  endfunction

  function automatic longint unsigned luminance_q32(input color_t c);
    return LUM_W_RED * lin_q16[c.red] + LUM_W_GREEN * lin_q16[c.green]
         + LUM_W_BLUE * lin_q16[c.blue];
  endfunction

  function automatic logic [RATIO_W-1:0] contrast_ratio_of(input color_t fore, input color_t back);
    longint unsigned la;
    longint unsigned lb;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    la = luminance_q32(fore);
    lb = luminance_q32(back);
    num = ((la > lb ? la : lb) + LUM_PAD) << SCALE;
    den = (la > lb ? lb : la) + LUM_PAD;
    q = (num + (den >> 1)) / den;
    if (q < RATIO_ONE) q = RATIO_ONE;
    if (q > RATIO_TOP) q = RATIO_TOP;
    return q[RATIO_W-1:0];
  endfunction

  function automatic int sender_idle_pct(input idle_mode_t m);
    return (m == IDLE_SENDER) ? 54 : (m == IDLE_BOTH) ? 24 : 0;
  endfunction

  function automatic int receiver_stall_pct(input idle_mode_t m);
    return (m == IDLE_RECEIVER) ? 54 : (m == IDLE_BOTH) ? 24 : 0;
  endfunction

  // Weighted toward black, white and the linear/curve boundary
  function automatic logic [CODE_W-1:0] random_code();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return CODE_W'($urandom_range(13, 8));
      default: return CODE_W'($urandom_range(255));
    endcase
  endfunction

  // One beat; valid stays up with a fixed payload until the core takes it
  task automatic send_pair(input color_t fore, input color_t back,
                           input logic [RATIO_W-1:0] want);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_fg_red <= fore.red;
    in_fg_green <= fore.green;
    in_fg_blue <= fore.blue;
    in_bg_red <= back.red;
    in_bg_green <= back.green;
    in_bg_blue <= back.blue;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_ratios.push_back(want);
    pairs_sent++;
  endtask

  // Hold off the sender until every ratio in flight is back
  task automatic drain_pending();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ratios.size() == 0) begin
        $display("%0t: unexpected ratio beat, got %0d", $time, out_ratio_q16);
        error_count++;
      end else begin
        ratio_want = pending_ratios.pop_front();
        ratios_checked++;
        if (out_ratio_q16 !== ratio_want) begin
          $display("%0t: ratio_q16 mismatch, expected %0d got %0d",
                   $time, ratio_want, out_ratio_q16);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d ratios outstanding",
             cycle_count, pending_ratios.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    color_t fore;
    color_t back;
    dir_row_t row;
    for (int i = 0; i < 256; i++) begin
      lin_q16[i] = srgb_to_linear_q16(i);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      send_pair(row.fore, row.back,
                row.typed ? row.ratio : contrast_ratio_of(row.fore, row.back));
    end
    drain_pending();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      repeat (PHASE_PAIRS) begin
        fore = {random_code(), random_code(), random_code()};
        back = {random_code(), random_code(), random_code()};
        case ($urandom_range(9))
          0, 1: back = fore;
          2: begin
            fore = {3{fore.red}};
            back = {3{back.red}};
          end
          default: ;
        endcase
        send_pair(fore, back, contrast_ratio_of(fore, back));
      end
      drain_pending();
    end

    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_ratios.size() != 0) begin
      $display("%0t: %0d expected ratios never arrived", $time, pending_ratios.size());
      error_count++;
    end

    $display("%0d color pairs (%0d directed), %0d ratios checked, %0d errors",
             pairs_sent, DIR_ROWS, ratios_checked, error_count);
    $display("idle patterns: none, sender gaps, receiver stalls, both");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/scr_pkg.sv
hdl/scr_luma.sv
hdl/scr_order.sv
hdl/scr_div.sv
hdl/srgb_contrast_ratio_core.sv
bench/tb_srgb_contrast_ratio_core.sv
